FILE: sv/np2sa_pkg.sv
// Shared types, constants and face tables for the nested pixel to angles block.
`timescale 1ns / 1ps

package np2sa_pkg;

  // Highest supported resolution order and derived widths
  localparam int MAX_ORDER = 29;
  localparam int ORDER_W   = 5;
  localparam int PIX_W     = 62;
  localparam int POS_W     = MAX_ORDER;      // x and y grid position
  localparam int NSIDE_W   = MAX_ORDER + 1;  // holds nside itself
  localparam int Z_W       = 64;
  localparam int PHI_W     = 63;
  localparam int M_W       = 33;             // phi numerator 2*jp - shift - 1
  localparam int QUO_W     = 64;             // quotient bits from the divider
  localparam int DIVD_W    = 93;             // dividend floor(m * pi * 2^124 / 2^65)

  // floor(pi * 2^124) as 32-bit limbs, least significant first
  localparam logic [31:0] PI_LIMB0 = 32'hE0370734;
  localparam logic [31:0] PI_LIMB1 = 32'h313198A2;
  localparam logic [31:0] PI_LIMB2 = 32'h885A308D;
  localparam logic [31:0] PI_LIMB3 = 32'h3243F6A8;

  // ceil(2^33 / 3): floor(c / 3) = (c * RECIP3) >> 33 for c below 2^32
  localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

  // (2^64 - 1) / 3: shifted right by 64 - k it gives floor(2^k / 3)
  localparam logic [63:0] THIRD_ONES = 64'h5555555555555555;

  // One in z fixed point (62 fraction bits)
  localparam logic [63:0] Z_ONE = 64'h4000000000000000;

  // Result fields that ride along with an item through the divider
  typedef struct packed {
    logic [Z_W-1:0] z;
    logic           oor;
  } np2sa_side_t;

  // Ring row of a base face, in units of nside
  function automatic logic [2:0] face_row(input logic [3:0] face);
    logic [2:0] row;
    case (face)
      4'd0, 4'd1, 4'd2, 4'd3:   row = 3'd2;
      4'd4, 4'd5, 4'd6, 4'd7:   row = 3'd3;
      4'd8, 4'd9, 4'd10, 4'd11: row = 3'd4;
      default:                  row = 3'd0;
    endcase
    return row;
  endfunction

  // Longitude column of a base face, in units of the ring quarter
  function automatic logic [2:0] face_col(input logic [3:0] face);
    logic [2:0] col;
    case (face)
      4'd0, 4'd8:  col = 3'd1;
      4'd1, 4'd9:  col = 3'd3;
      4'd2, 4'd10: col = 3'd5;
      4'd3, 4'd11: col = 3'd7;
      4'd4:        col = 3'd0;
      4'd5:        col = 3'd2;
      4'd6:        col = 3'd4;
      4'd7:        col = 3'd6;
      default:     col = 3'd0;
    endcase
    return col;
  endfunction

endpackage

FILE: sv/np2sa_if.sv
// Valid/ready channel interfaces for pixel indexes and sphere angles.
`timescale 1ns / 1ps

interface np2sa_pix_if;
  logic                        valid;
  logic                        ready;
  logic [np2sa_pkg::PIX_W-1:0] pixel_index;

  modport source (output valid, output pixel_index, input ready);
  modport sink   (input valid, input pixel_index, output ready);
endinterface

interface np2sa_ang_if;
  logic                        valid;
  logic                        ready;
  logic [np2sa_pkg::Z_W-1:0]   z_value;
  logic [np2sa_pkg::PHI_W-1:0] phi_value;
  logic                        index_out_of_range;

  modport source (output valid, output z_value, output phi_value,
                  output index_out_of_range, input ready);
  modport sink   (input valid, input z_value, input phi_value,
                  input index_out_of_range, output ready);
endinterface

FILE: sv/nested_pixel_to_sphere_angles_top.sv
// Top level: nested pixel index to z = cos(colatitude) and longitude phi.
// Throughput: one pixel per cycle while the skid entry is empty; nine arithmetic
// register stages, a 32-stage divider (two quotient bits per stage, for phi) and a result
// stage lie before the output register.
// Output register plus one skid entry; input ready drops only when the skid is full.
// Reset (rst, synchronous) clears all valid bits and sets the order register to 0.
`timescale 1ns / 1ps

module nested_pixel_to_sphere_angles_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [np2sa_pkg::ORDER_W-1:0]     cfg_data,
  np2sa_pix_if.sink                         pix_in,
  np2sa_ang_if.source                       ang_out
);

  localparam int OW  = np2sa_pkg::ORDER_W;
  localparam int PW  = np2sa_pkg::PIX_W;
  localparam int XW  = np2sa_pkg::POS_W;
  localparam int NW  = np2sa_pkg::NSIDE_W;
  localparam int ZW  = np2sa_pkg::Z_W;
  localparam int FW  = np2sa_pkg::PHI_W;
  localparam int MW  = np2sa_pkg::M_W;
  localparam int QW  = np2sa_pkg::QUO_W;
  localparam int DW  = np2sa_pkg::DIVD_W;
  localparam int SW  = NW - 1;          // floor(c / 3)
  localparam int PPW = MW + 32;         // one partial product
  localparam int HW  = PPW + 32;        // half product
  localparam int RGW = NW + 2;          // ring number
  localparam int NMW = RGW + 3;         // signed ring position numerator
  localparam int UW  = 2 * SW + 2;      // floor(value / 3) before scaling

  logic [OW-1:0] order;
  logic          en;
  logic          accept;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      order <= '0;
    end else if (cfg_we) begin
      order <= cfg_data;
    end
  end

  logic s_valid;
  assign en           = !s_valid;
  assign pix_in.ready = en;
  assign accept       = pix_in.valid && en;

  // ---------------- stage 1: capture pixel and saturated order
  logic          v1;
  logic [PW-1:0] p1_pix;
  logic [OW-1:0] p1_n;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= accept;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_pix <= pix_in.pixel_index;
      p1_n   <= (order > OW'(np2sa_pkg::MAX_ORDER)) ? OW'(np2sa_pkg::MAX_ORDER) : order;
    end
  end

  // ---------------- stage 2: range check, face split, deinterleave
  logic [63:0]   s2_fsz;
  logic [63:0]   s2_cnt;
  logic [63:0]   s2_face_w;
  logic [PW-1:0] s2_local;
  logic [XW-1:0] s2_ix;
  logic [XW-1:0] s2_iy;

  always_comb begin
    s2_fsz    = 64'd1 << {p1_n, 1'b0};
    s2_cnt    = (s2_fsz << 3) + (s2_fsz << 2);
    s2_face_w = {2'b0, p1_pix} >> {p1_n, 1'b0};
    s2_local  = p1_pix & (s2_fsz[PW-1:0] - PW'(1));
    for (int i = 0; i < XW; i++) begin
      s2_ix[i] = s2_local[2*i];
      s2_iy[i] = s2_local[2*i+1];
    end
  end

  logic          v2;
  logic          p2_oor;
  logic [3:0]    p2_face;
  logic [XW-1:0] p2_ix;
  logic [XW-1:0] p2_iy;
  logic [OW-1:0] p2_n;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_oor  <= ({2'b0, p1_pix} >= s2_cnt);
      p2_face <= s2_face_w[3:0];
      p2_ix   <= s2_ix;
      p2_iy   <= s2_iy;
      p2_n    <= p1_n;
    end
  end

  // ---------------- stage 3: ring number
  logic [NW-1:0]  s3_nside;
  logic [2:0]     s3_row;
  logic [RGW-1:0] s3_rowns;

  always_comb begin
    s3_nside = NW'(1) << p2_n;
    s3_row   = np2sa_pkg::face_row(p2_face);
    s3_rowns = (s3_row[2] ? {s3_nside, 2'b0} : '0)
             + (s3_row[1] ? {1'b0, s3_nside, 1'b0} : '0)
             + (s3_row[0] ? {2'b0, s3_nside} : '0);
  end

  logic           v3;
  logic           p3_oor;
  logic [RGW-1:0] p3_ring;
  logic [2:0]     p3_col;
  logic [XW-1:0]  p3_ix;
  logic [XW-1:0]  p3_iy;
  logic [OW-1:0]  p3_n;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_oor  <= p2_oor;
      p3_ring <= s3_rowns - RGW'(p2_ix) - RGW'(p2_iy) - RGW'(1);
      p3_col  <= np2sa_pkg::face_col(p2_face);
      p3_ix   <= p2_ix;
      p3_iy   <= p2_iy;
      p3_n    <= p2_n;
    end
  end

  // ---------------- stage 4: region, ring length, distance from equator
  logic [NW-1:0]  s4_nside;
  logic [RGW-1:0] s4_ns4;
  logic [RGW-1:0] s4_ns3;
  logic           s4_north;
  logic           s4_south;
  logic [RGW-1:0] s4_sdist;
  logic [RGW:0]   s4_d;
  logic [RGW:0]   s4_dneg_v;
  logic [NW-1:0]  s4_a;
  logic [NW-1:0]  s4_r;

  always_comb begin
    s4_nside  = NW'(1) << p3_n;
    s4_ns4    = {s4_nside, 2'b0};
    s4_ns3    = {2'b0, s4_nside} + {1'b0, s4_nside, 1'b0};
    s4_north  = p3_ring < {2'b0, s4_nside};
    s4_south  = p3_ring > s4_ns3;
    s4_sdist  = s4_ns4 - p3_ring;
    s4_d      = {2'b0, s4_nside, 1'b0} - {1'b0, p3_ring};
    s4_dneg_v = (RGW+1)'(0) - s4_d;
    s4_a      = s4_d[RGW] ? s4_dneg_v[NW-1:0] : s4_d[NW-1:0];
    if (s4_north)      s4_r = p3_ring[NW-1:0];
    else if (s4_south) s4_r = s4_sdist[NW-1:0];
    else               s4_r = s4_nside;
  end

  logic          v4;
  logic          p4_oor;
  logic [NW-1:0] p4_r;
  logic [NW-1:0] p4_c;
  logic          p4_cap;
  logic          p4_north;
  logic          p4_dneg;
  logic          p4_shift;
  logic [2:0]    p4_col;
  logic [XW-1:0] p4_ix;
  logic [XW-1:0] p4_iy;
  logic [OW-1:0] p4_n;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_oor   <= p3_oor;
      p4_r     <= s4_r;
      p4_c     <= (s4_north || s4_south) ? s4_r : s4_a;
      p4_cap   <= s4_north || s4_south;
      p4_north <= s4_north;
      p4_dneg  <= s4_d[RGW];
      p4_shift <= !(s4_north || s4_south) && (p3_ring[0] ^ s4_nside[0]);
      p4_col   <= p3_col;
      p4_ix    <= p3_ix;
      p4_iy    <= p3_iy;
      p4_n     <= p3_n;
    end
  end

  // ---------------- stage 5: ring position numerator, divide-by-3 product
  logic [RGW:0]          s5_colr;
  logic signed [NMW-1:0] s5_num;

  always_comb begin
    s5_colr = (p4_col[2] ? {1'b0, p4_r, 2'b0} : '0)
            + (p4_col[1] ? {2'b0, p4_r, 1'b0} : '0)
            + (p4_col[0] ? {3'b0, p4_r} : '0);
    s5_num  = $signed({2'b0, s5_colr}) + $signed(NMW'(p4_ix)) - $signed(NMW'(p4_iy))
            + $signed(NMW'(1)) + $signed(NMW'(p4_shift));
  end

  logic                  v5;
  logic                  p5_oor;
  logic signed [NMW-1:0] p5_num;
  logic [NW+31:0]        p5_cprod;
  logic [NW-1:0]         p5_c;
  logic [NW-1:0]         p5_r;
  logic                  p5_cap;
  logic                  p5_north;
  logic                  p5_dneg;
  logic                  p5_shift;
  logic [OW-1:0]         p5_n;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_oor   <= p4_oor;
      p5_num   <= s5_num;
      p5_cprod <= (NW+32)'(p4_c) * (NW+32)'(np2sa_pkg::RECIP3);
      p5_c     <= p4_c;
      p5_r     <= p4_r;
      p5_cap   <= p4_cap;
      p5_north <= p4_north;
      p5_dneg  <= p4_dneg;
      p5_shift <= p4_shift;
      p5_n     <= p4_n;
    end
  end

  // ---------------- stage 6: quotient and remainder by 3, wrap jp, form m
  logic [SW-1:0]         s6_s;
  logic [NW:0]           s6_s3;
  logic [NW:0]           s6_wv;
  logic [NW-1:0]         s6_nside;
  logic signed [NMW-1:0] s6_nl4;
  logic signed [NMW-1:0] s6_half;
  logic signed [NMW-1:0] s6_jp1;
  logic signed [NMW-1:0] s6_jp2;
  logic signed [NMW-1:0] s6_m;

  always_comb begin
    s6_s     = p5_cprod[NW+31:33];
    s6_s3    = (NW+1)'(s6_s) + {(NW+1)'(s6_s) << 1};
    s6_wv    = {1'b0, p5_c} - s6_s3;
    s6_nside = NW'(1) << p5_n;
    s6_nl4   = $signed({3'b0, s6_nside, 2'b0});
    s6_half  = p5_num[NMW-1] ? ((p5_num + $signed(NMW'(1))) >>> 1) : (p5_num >>> 1);
    s6_jp1   = (s6_half > s6_nl4) ? (s6_half - s6_nl4) : s6_half;
    s6_jp2   = (s6_jp1 < $signed(NMW'(1))) ? (s6_jp1 + s6_nl4) : s6_jp1;
    s6_m     = (s6_jp2 <<< 1) - $signed(NMW'(p5_shift)) - $signed(NMW'(1));
  end

  logic          v6;
  logic          p6_oor;
  logic [SW-1:0] p6_s;
  logic [1:0]    p6_w;
  logic [MW-1:0] p6_m;
  logic [NW-1:0] p6_r;
  logic          p6_cap;
  logic          p6_north;
  logic          p6_dneg;
  logic [OW-1:0] p6_n;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6_oor   <= p5_oor;
      p6_s     <= s6_s;
      p6_w     <= s6_wv[1:0];
      p6_m     <= s6_m[MW-1:0];
      p6_r     <= p5_r;
      p6_cap   <= p5_cap;
      p6_north <= p5_north;
      p6_dneg  <= p5_dneg;
      p6_n     <= p5_n;
    end
  end

  // ---------------- stage 7: square of c/3 and pi partial products
  logic           v7;
  logic           p7_oor;
  logic [2*SW-1:0] p7_ssq;
  logic [SW+1:0]  p7_sw;
  logic [PPW-1:0] p7_pp0;
  logic [PPW-1:0] p7_pp1;
  logic [PPW-1:0] p7_pp2;
  logic [PPW-1:0] p7_pp3;
  logic [SW-1:0]  p7_s;
  logic [1:0]     p7_w;
  logic [NW-1:0]  p7_r;
  logic           p7_cap;
  logic           p7_north;
  logic           p7_dneg;
  logic [OW-1:0]  p7_n;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p7_oor   <= p6_oor;
      p7_ssq   <= (2*SW)'(p6_s) * (2*SW)'(p6_s);
      p7_sw    <= (p6_w[1] ? {1'b0, p6_s, 1'b0} : '0) + (p6_w[0] ? {2'b0, p6_s} : '0);
      p7_pp0   <= PPW'(p6_m) * PPW'(np2sa_pkg::PI_LIMB0);
      p7_pp1   <= PPW'(p6_m) * PPW'(np2sa_pkg::PI_LIMB1);
      p7_pp2   <= PPW'(p6_m) * PPW'(np2sa_pkg::PI_LIMB2);
      p7_pp3   <= PPW'(p6_m) * PPW'(np2sa_pkg::PI_LIMB3);
      p7_s     <= p6_s;
      p7_w     <= p6_w;
      p7_r     <= p6_r;
      p7_cap   <= p6_cap;
      p7_north <= p6_north;
      p7_dneg  <= p6_dneg;
      p7_n     <= p6_n;
    end
  end

  // ---------------- stage 8: value/3 split, scale exponent, half products
  logic           v8;
  logic           p8_oor;
  logic [UW-1:0]  p8_u;
  logic [1:0]     p8_v;
  logic [5:0]     p8_k;
  logic [HW-1:0]  p8_lo;
  logic [HW-1:0]  p8_hi;
  logic [NW-1:0]  p8_r;
  logic           p8_cap;
  logic           p8_north;
  logic           p8_dneg;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p8_oor   <= p7_oor;
      // polar caps split r^2 = 3u + v from r = 3s + w; the belt uses |d| = 3s + w
      p8_u     <= p7_cap ? (UW'(p7_ssq) + (UW'(p7_ssq) << 1) + (UW'(p7_sw) << 1)
                            + UW'(p7_w == 2'd2))
                         : UW'(p7_s);
      p8_v     <= p7_cap ? {1'b0, (p7_w != 2'd0)} : p7_w;
      p8_k     <= p7_cap ? (6'd62 - {p7_n, 1'b0}) : (6'd63 - {1'b0, p7_n});
      p8_lo    <= HW'(p7_pp0) + (HW'(p7_pp1) << 32);
      p8_hi    <= HW'(p7_pp2) + (HW'(p7_pp3) << 32);
      p8_r     <= p7_r;
      p8_cap   <= p7_cap;
      p8_north <= p7_north;
      p8_dneg  <= p7_dneg;
    end
  end

  // ---------------- stage 9: round(x / 3) and full pi product
  logic [63:0]  s9_t;
  logic [63:0]  s9_vt;
  logic         s9_bump;
  logic [159:0] s9_prod;

  always_comb begin
    s9_t    = np2sa_pkg::THIRD_ONES >> (7'd64 - {1'b0, p8_k});
    s9_vt   = p8_v[1] ? (s9_t << 1) : (p8_v[0] ? s9_t : 64'd0);
    // round half never occurs: add one where (v * (2^k mod 3) + 1) reaches 3
    s9_bump = p8_v[1] || (p8_v[0] && p8_k[0]);
    s9_prod = 160'(p8_lo) + (160'(p8_hi) << 64);
  end

  logic          v9;
  logic          p9_oor;
  logic [63:0]   p9_xq;
  logic [DW-1:0] p9_divd;
  logic [NW-1:0] p9_r;
  logic          p9_cap;
  logic          p9_north;
  logic          p9_dneg;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p9_oor   <= p8_oor;
      p9_xq    <= (64'(p8_u) << p8_k) + s9_vt + 64'(s9_bump);
      p9_divd  <= s9_prod[DW+64:65];
      p9_r     <= p8_r;
      p9_cap   <= p8_cap;
      p9_north <= p8_north;
      p9_dneg  <= p8_dneg;
    end
  end

  // ---------------- stage 10: sign z, feed the divider
  np2sa_pkg::np2sa_side_t s10_side;

  always_comb begin
    s10_side.oor = p9_oor;
    if (p9_oor)                    s10_side.z = '0;
    else if (p9_cap && p9_north)   s10_side.z = np2sa_pkg::Z_ONE - p9_xq;
    else if (p9_cap)               s10_side.z = p9_xq - np2sa_pkg::Z_ONE;
    else if (p9_dneg)              s10_side.z = 64'd0 - p9_xq;
    else                           s10_side.z = p9_xq;
  end

  logic                   dv_valid;
  logic [QW-1:0]          dv_quo;
  np2sa_pkg::np2sa_side_t dv_side;

  np2sa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v9),
    .dividend  (p9_divd),
    .divisor   (p9_r),
    .in_side   (s10_side),
    .out_valid (dv_valid),
    .quotient  (dv_quo),
    .out_side  (dv_side)
  );

  // ---------------- result stage: round phi half up
  logic [QW:0]   sf_round;
  assign sf_round = {1'b0, dv_quo} + (QW+1)'(1);

  logic          vf;
  logic [ZW-1:0] pf_z;
  logic [FW-1:0] pf_phi;
  logic          pf_oor;

  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else if (en) vf <= dv_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pf_z   <= dv_side.z;
      pf_phi <= dv_side.oor ? '0 : sf_round[FW:1];
      pf_oor <= dv_side.oor;
    end
  end

  // ---------------- output register and skid entry
  logic          o_valid;
  logic [ZW-1:0] o_z;
  logic [FW-1:0] o_phi;
  logic          o_oor;
  logic [ZW-1:0] s_z;
  logic [FW-1:0] s_phi;
  logic          s_oor;
  logic          push;
  logic          o_free;

  assign push   = en && vf;
  assign o_free = !o_valid || ang_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= s_valid || push;
      s_valid <= 1'b0;
    end else if (push) begin
      s_valid <= 1'b1;
    end
  end

  // Move skid into the output first, else take the pipeline result
  always_ff @(posedge clk) begin
    if (o_free) begin
      if (s_valid) begin
        o_z   <= s_z;
        o_phi <= s_phi;
        o_oor <= s_oor;
      end else begin
        o_z   <= pf_z;
        o_phi <= pf_phi;
        o_oor <= pf_oor;
      end
    end else if (push) begin
      s_z   <= pf_z;
      s_phi <= pf_phi;
      s_oor <= pf_oor;
    end
  end

  assign ang_out.valid              = o_valid;
  assign ang_out.z_value            = o_z;
  assign ang_out.phi_value          = o_phi;
  assign ang_out.index_out_of_range = o_oor;

  // ---------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid entry holds a transaction while the output is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (s_valid && !ang_out.ready) |=> s_valid)
    else $error("skid transaction dropped while output stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted transaction did not enter the first stage");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_oor) |-> (o_z == '0 && o_phi == '0))
    else $error("out of range result carries nonzero angles");

endmodule

FILE: sv/np2sa_div.sv
// Pipelined restoring divider, two quotient bits per stage, for the phi numerator.
`timescale 1ns / 1ps

module np2sa_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [np2sa_pkg::DIVD_W-1:0]     dividend,
  input  logic [np2sa_pkg::NSIDE_W-1:0]    divisor,
  input  np2sa_pkg::np2sa_side_t           in_side,
  output logic                             out_valid,
  output logic [np2sa_pkg::QUO_W-1:0]      quotient,
  output np2sa_pkg::np2sa_side_t           out_side
);

  localparam int QW       = np2sa_pkg::QUO_W;
  localparam int RW       = np2sa_pkg::NSIDE_W;
  localparam int PER      = 2;
  localparam int STAGES   = QW / PER;
  localparam int DIVD_TOP = np2sa_pkg::DIVD_W;

  logic                   vld   [STAGES];
  logic [RW-1:0]          rem   [STAGES];
  logic [QW-1:0]          low   [STAGES];
  logic [QW-1:0]          quo   [STAGES];
  logic [RW-1:0]          dvs   [STAGES];
  np2sa_pkg::np2sa_side_t side  [STAGES];

  logic [RW-1:0]          rem_next [STAGES];
  logic [QW-1:0]          low_next [STAGES];
  logic [QW-1:0]          quo_next [STAGES];

  // Run PER shift-compare-subtract steps on each stage's input
  always_comb begin
    logic [RW-1:0] cr;
    logic [QW-1:0] cl;
    logic [QW-1:0] cq;
    logic [RW-1:0] cd;
    logic [RW:0]   trial;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        cr = RW'(dividend[DIVD_TOP-1:QW]);
        cl = dividend[QW-1:0];
        cq = '0;
        cd = divisor;
      end else begin
        cr = rem[i-1];
        cl = low[i-1];
        cq = quo[i-1];
        cd = dvs[i-1];
      end
      for (int j = 0; j < PER; j++) begin
        trial = {cr, cl[QW-1]};
        cl    = {cl[QW-2:0], 1'b0};
        if (trial >= {1'b0, cd}) begin
          trial = trial - {1'b0, cd};
          cq    = {cq[QW-2:0], 1'b1};
        end else begin
          cq    = {cq[QW-2:0], 1'b0};
        end
        cr = trial[RW-1:0];
      end
      rem_next[i] = cr;
      low_next[i] = cl;
      quo_next[i] = cq;
    end
  end

  // Advance valid bits with the stall
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) vld[i] <= vld[i-1];
    end
  end

  // Advance partial remainders, quotients and side fields
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < STAGES; i++) begin
        rem[i] <= rem_next[i];
        low[i] <= low_next[i];
        quo[i] <= quo_next[i];
      end
      dvs[0]  <= divisor;
      side[0] <= in_side;
      for (int i = 1; i < STAGES; i++) begin
        dvs[i]  <= dvs[i-1];
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign quotient  = quo[STAGES-1];
  assign out_side  = side[STAGES-1];

endmodule

FILE: dv/np2sa_tb_if.sv
// Testbench-side types for the angle channel; the RTL channel interfaces are used as they are.
`timescale 1ns / 1ps

// The RTL interfaces np2sa_pix_if and np2sa_ang_if are used as they are;
// this file only holds the testbench-side angle record shared by the bench.
package np2sa_tb_pkg;

  // One expected or observed transaction on the angle channel
  typedef struct {
    logic [63:0] z;
    logic [62:0] phi;
    logic        oor;
  } sphere_angles_t;

endpackage

FILE: dv/nested_pixel_to_sphere_angles_top_tb.sv
// Testbench for the nested pixel to sphere angles block.
`timescale 1ns / 1ps

module nested_pixel_to_sphere_angles_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int OW = np2sa_pkg::ORDER_W;
  localparam int PW = np2sa_pkg::PIX_W;
  localparam int MAXO = np2sa_pkg::MAX_ORDER;
  localparam logic [127:0] PI_Q124 = 128'h3243F6A8885A308D313198A2E0370734;
  localparam int ROW_OF_FACE [12] = '{2, 2, 2, 2, 3, 3, 3, 3, 4, 4, 4, 4};
  localparam int COL_OF_FACE [12] = '{1, 3, 5, 7, 0, 2, 4, 6, 1, 3, 5, 7};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [OW-1:0] cfg_data;

  np2sa_pix_if pix ();
  np2sa_ang_if ang ();

  nested_pixel_to_sphere_angles_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .pix_in   (pix.sink),
    .ang_out  (ang.source)
  );

  np2sa_tb_pkg::sphere_angles_t pending_angles[$];
  logic [OW-1:0] cur_order;
  int   mismatches = 0;
  int   cycles = 0;
  bit   idle_on;
  int   stall_len = 0;
  bit   stall_taken;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected angles for one pixel at a given order
  function automatic np2sa_tb_pkg::sphere_angles_t predict_angles(input logic [OW-1:0] ord,
                                                                  input logic [PW-1:0] pixel);
    int unsigned n;
    logic [63:0] nside, fsz, face, loc, ix, iy, r, x, q, zv, mm, phi_t;
    longint ring, d, num, jp, sh, nl4;
    logic [159:0] prod, quo;
    np2sa_tb_pkg::sphere_angles_t a;
    n = (ord > MAXO) ? MAXO : ord;
    nside = 64'd1 << n;
    fsz = 64'd1 << (2 * n);
    a.z = '0;
    a.phi = '0;
    a.oor = 1'b0;
    if (64'(pixel) >= 64'd12 * fsz) begin
      a.oor = 1'b1;
      return a;
    end
    face = 64'(pixel) >> (2 * n);
    loc = 64'(pixel) & (fsz - 64'd1);
    ix = '0;
    iy = '0;
    for (int i = 0; i < n; i++) begin
      ix[i] = loc[2 * i];
      iy[i] = loc[2 * i + 1];
    end
    nl4 = longint'(4 * nside);
    ring = longint'(ROW_OF_FACE[face] * nside) - longint'(ix) - longint'(iy) - 1;
    if (ring < longint'(nside)) begin
      // north cap
      r = 64'(ring);
      x = (r * r) << (62 - 2 * n);
      zv = (64'd1 << 62) - (x + 64'd1) / 64'd3;
      sh = 0;
    end else if (ring > longint'(3 * nside)) begin
      // south cap
      r = 64'(nl4 - ring);
      x = (r * r) << (62 - 2 * n);
      zv = (x + 64'd1) / 64'd3 - (64'd1 << 62);
      sh = 0;
    end else begin
      // equatorial belt
      d = longint'(2 * nside) - ring;
      x = 64'(d < 0 ? -d : d) << (63 - n);
      q = x / 64'd3 + ((x % 64'd3) == 64'd2 ? 64'd1 : 64'd0);
      zv = (d < 0) ? 64'd0 - q : q;
      r = nside;
      sh = (ring - longint'(nside)) & 1;
    end
    num = longint'(COL_OF_FACE[face] * r) + longint'(ix) - longint'(iy) + 1 + sh;
    jp = num / 2;
    if (jp > nl4) jp -= nl4;
    if (jp < 1) jp += nl4;
    mm = 64'(2 * jp - sh - 1);
    prod = 160'(mm) * 160'(PI_Q124);
    quo = prod / 160'(r);
    phi_t = quo[129:66] + 64'(quo[65]);
    a.z = zv;
    a.phi = phi_t[62:0];
    return a;
  endfunction

  function automatic logic [PW-1:0] rand_pixel();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[PW-1:0];
  endfunction

  function automatic logic [63:0] pixel_count(input logic [OW-1:0] ord);
    int unsigned n;
    n = (ord > MAXO) ? MAXO : ord;
    return 64'd12 << (2 * n);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Record each pixel transaction with its expected angles
  always @(posedge clk) begin
    if (!rst && pix.valid && pix.ready)
      pending_angles.push_back(predict_angles(cur_order, pix.pixel_index));
  end

  // Check each angle transaction against the oldest expectation
  always @(posedge clk) begin
    np2sa_tb_pkg::sphere_angles_t want;
    if (!rst && ang.valid && ang.ready) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected result", ang.z_value, 64'd0);
      end else begin
        want = pending_angles.pop_front();
        if (ang.z_value !== want.z) report_mismatch("z_value", ang.z_value, want.z);
        if (ang.phi_value !== want.phi)
          report_mismatch("phi_value", 64'(ang.phi_value), 64'(want.phi));
        if (ang.index_out_of_range !== want.oor)
          report_mismatch("index_out_of_range", 64'(ang.index_out_of_range), 64'(want.oor));
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random ready, with one counted hold-off on request
  initial begin
    ang.ready = 1'b0;
    stall_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_len > 0 && !stall_taken) begin
        stall_taken = 1'b1;
        ang.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
      ang.ready <= idle_on ? ($urandom_range(99) >= 37) : 1'b1;
    end
  end

  // Offer one pixel, idling first at random, and hold until it is taken
  task automatic send_pixel(input logic [PW-1:0] pixel);
    if (idle_on && $urandom_range(99) < 37) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_index <= pixel;
    do @(posedge clk); while (!pix.ready);
  endtask

  // Drain, then write the order register
  task automatic set_order(input logic [OW-1:0] ord);
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= ord;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_order = ord;
  endtask

  // A pixel at the order, out of range about one time in ten
  task automatic send_random_pixel();
    logic [63:0] cnt;
    cnt = pixel_count(cur_order);
    if ($urandom_range(9) == 0)
      send_pixel(PW'(cnt + (64'(rand_pixel()) % ((64'd1 << PW) - cnt))));
    else
      send_pixel(PW'(64'(rand_pixel()) % cnt));
  endtask

  task automatic test_order_zero();
    set_order(5'd0);
    for (int i = 0; i < 13; i++) send_pixel(PW'(i));
    send_pixel('1);
  endtask

  task automatic test_extremes();
    logic [63:0] cnt;
    set_order(5'd29);
    cnt = pixel_count(5'd29);
    send_pixel('0);
    send_pixel(PW'(cnt - 1));
    send_pixel(PW'(cnt));
    send_pixel('1);
    // face corners: the northern corner of each face
    for (int f = 0; f < 12; f++) begin
      send_pixel(PW'((64'(f) << 58) | ((64'd1 << 58) - 1)));
    end
    send_pixel(PW'({31{2'b01}}) & PW'((64'd1 << 58) - 1));
    send_pixel(PW'({31{2'b10}}) & PW'((64'd1 << 58) - 1));
  endtask

  task automatic test_saturation();
    set_order(5'd31);
    for (int i = 0; i < 6; i++) send_random_pixel();
    set_order(5'd30);
    send_pixel(PW'(pixel_count(5'd29) - 1));
    send_pixel(PW'(pixel_count(5'd29)));
  endtask

  task automatic test_order_sweep();
    for (int o = 0; o <= 31; o++) begin
      set_order(OW'(o));
      // no idling on either side for orders 12 to 15
      idle_on = !(o >= 12 && o < 16);
      for (int i = 0; i < 48; i++) send_random_pixel();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_back_pressure();
    set_order(5'd10);
    stall_len = 300;
    for (int i = 0; i < 120; i++) send_random_pixel();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.pixel_index = '0;
    cur_order = '0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_order_zero();
    test_extremes();
    test_saturation();
    test_order_sweep();
    test_back_pressure();

    pix.valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
